/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies; clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// property that holds in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/apci_win_pkg.sv */
// constants and codes for the apci window engine
// no dependencies
`timescale 1ns / 1ps

package apci_win_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int SEQ_W            = 15;

    localparam logic [SEQ_W-1:0] SEQ_MAX = 15'h7fff;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [4:0] WINDOW_SIZE_RST = 5'd12;

    // control field masks of u frames, the s frame code and the sequence lsb mask
    localparam logic [7:0] MASK_TESTFR_ACT = 8'h43;
    localparam logic [7:0] MASK_STARTDT    = 8'h07;
    localparam logic [7:0] MASK_STOPDT     = 8'h13;
    localparam logic [7:0] MASK_TESTFR_CON = 8'h83;
    localparam logic [7:0] CTL_S_FRAME     = 8'h01;
    localparam logic [7:0] SEQ_LSB_MASK    = 8'hfe;

    // reply control octets
    localparam logic [7:0] REPLY_TESTFR_CON  = 8'h83;
    localparam logic [7:0] REPLY_STARTDT_CON = 8'h0b;
    localparam logic [7:0] REPLY_STOPDT_CON  = 8'h23;
    localparam logic [7:0] REPLY_S_FRAME     = 8'h01;
    localparam logic [7:0] U_FRAME_LENGTH    = 8'd4;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_START   = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
    localparam logic [2:0] ST_I_SHORT     = 3'd4;
    localparam logic [2:0] ST_NS_MISMATCH = 3'd5;
    localparam logic [2:0] ST_NR_RANGE    = 3'd6;
    localparam logic [2:0] ST_WINDOW_FULL = 3'd7;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_SEND    = 1'b1;

endpackage

/* hdl/iec104_apci_window_engine_unit.sv */
// iec 104 apci window engine, controlling-station side: top level
// depends on apci_win_pkg, apci_win_ring and assert_macros.svh
`timescale 1ns / 1ps
// usage
//   item channel: item_valid / item_stall with command, start_byte, length_byte,
//     msg_size, ctl1..ctl4, send_size; an item is taken when valid is high and
//     stall is low. stall is high while an item is being worked on.
//   result channel: result_valid / result_stall, one registered result item;
//     a stopdt act gives two items, the last one flagged by last.
//   window_size_we writes window_size (k) at any edge; write it only when idle.
// steps and throughput
//   simple frames, errors and sends: exec, then emit to the output register;
//   i and s frames on an empty ring: exec, ack, emit; n(r) refused by pending
//   entries: exec, newest read, oldest read, emit. i and s frames retiring
//   pending entries: the reads, then a walk step for each entry retired (at least
//   one), paced by the ring memory's single registered read port, then ack and emit.
//   a new item is taken in the cycle after the last result is loaded, even
//   while that result still waits in the output register.
// reset
//   counters cleared, ring empty, window_size 12; ring contents unknown until written
// stalls
//   a stalled result holds; a later result waits in its state until the
//   output register frees, and no new item is taken meanwhile.

`include "assert_macros.svh"

module iec104_apci_window_engine_unit #(
    parameter int WINDOW_DEPTH = apci_win_pkg::WINDOW_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        window_size_we,
    input  logic [4:0]  window_size,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        command,
    input  logic [7:0]  start_byte,
    input  logic [7:0]  length_byte,
    input  logic [8:0]  msg_size,
    input  logic [7:0]  ctl1,
    input  logic [7:0]  ctl2,
    input  logic [7:0]  ctl3,
    input  logic [7:0]  ctl4,
    input  logic [7:0]  send_size,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic        has_frame,
    output logic [7:0]  out_length,
    output logic [7:0]  out_c1,
    output logic [7:0]  out_c2,
    output logic [7:0]  out_c3,
    output logic [7:0]  out_c4,
    output logic        deliver_payload,
    output logic        window_ready,
    output logic        ack_timer_running,
    output logic [14:0] unconfirmed_received,
    output logic        last
);

    localparam int SW  = apci_win_pkg::SEQ_W;
    localparam int SLW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int KW  = (SLW + 1 > 5) ? SLW + 1 : 5;
    localparam int GW  = $clog2(WINDOW_DEPTH + 2);

    localparam logic [KW-1:0] K_MAX     = KW'(WINDOW_DEPTH);
    localparam logic [GW-1:0] GUARD_END = GW'(WINDOW_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RDN   = 3'd2;
    localparam logic [2:0] S_RDO   = 3'd3;
    localparam logic [2:0] S_LOOP  = 3'd4;
    localparam logic [2:0] S_ACK   = 3'd5;
    localparam logic [2:0] S_EMIT1 = 3'd6;
    localparam logic [2:0] S_EMIT2 = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [4:0] wsize_reg;

    // latched item
    logic           cmd_reg, cmd_next;
    logic [7:0]     start_reg, start_next;
    logic [7:0]     lenb_reg, lenb_next;
    logic [8:0]     msize_reg, msize_next;
    logic [7:0]     c1_reg, c1_next, c2_reg, c2_next, c3_reg, c3_next, c4_reg, c4_next;
    logic [7:0]     ssize_reg, ssize_next;

    // protocol state
    logic [SLW-1:0] oldest_reg, oldest_next;
    logic [SLW-1:0] newest_reg, newest_next;
    logic           empty_reg, empty_next;
    logic [SW-1:0]  send_cnt_reg, send_cnt_next;
    logic [SW-1:0]  recv_cnt_reg, recv_cnt_next;
    logic [SW-1:0]  unconf_reg, unconf_next;
    logic           ack_flag_reg, ack_flag_next;

    // acknowledge walk
    logic [SW-1:0]  seq_reg, seq_next;
    logic           iframe_reg, iframe_next;
    logic [SW-1:0]  nval_reg, nval_next;
    logic           wrapped_reg, wrapped_next;
    logic [SW-1:0]  before_reg, before_next;
    logic [GW-1:0]  guard_reg, guard_next;

    // staged result
    logic [2:0]     rs_status_reg, rs_status_next;
    logic           rs_has_reg, rs_has_next;
    logic [7:0]     rs_len_reg, rs_len_next;
    logic [7:0]     rs_c1_reg, rs_c1_next, rs_c2_reg, rs_c2_next;
    logic [7:0]     rs_c3_reg, rs_c3_next, rs_c4_reg, rs_c4_next;
    logic           rs_dlv_reg, rs_dlv_next;
    logic           two_reg, two_next;

    // output register
    logic           ov_reg, ov_next;
    logic [2:0]     o_status_reg, o_status_next;
    logic           o_has_reg, o_has_next;
    logic [7:0]     o_len_reg, o_len_next;
    logic [7:0]     o_c1_reg, o_c1_next, o_c2_reg, o_c2_next;
    logic [7:0]     o_c3_reg, o_c3_next, o_c4_reg, o_c4_next;
    logic           o_dlv_reg, o_dlv_next;
    logic           o_wrdy_reg, o_wrdy_next;
    logic           o_ack_reg, o_ack_next;
    logic [SW-1:0]  o_unc_reg, o_unc_next;
    logic           o_last_reg, o_last_next;

    // ring port
    logic           ring_we, ring_re;
    logic [SLW-1:0] ring_waddr, ring_raddr;
    logic [SW-1:0]  ring_wdata, ring_rdata;

    logic [KW-1:0]  eff_k;
    logic           win_full;
    logic           out_free;
    logic [SW-1:0]  nr_field, ns_field;
    logic [SLW-1:0] slot_a, slot_b, nxt_newest;
    logic           seq_ok;

    function automatic logic [SLW-1:0] next_slot(input logic [SLW-1:0] i,
                                                  input logic [KW-1:0] k);
        logic [KW-1:0] n;
        n = KW'(i) + KW'(1);
        return (n >= k) ? '0 : n[SLW-1:0];
    endfunction

    // k clamped to 1..depth
    always_comb
    begin
        eff_k = KW'(wsize_reg);
        if (eff_k == '0)
        begin
            eff_k = KW'(1);
        end
        else if (eff_k > K_MAX)
        begin
            eff_k = K_MAX;
        end
    end

    assign nxt_newest = next_slot(newest_reg, eff_k);
    assign win_full   = !empty_reg && (nxt_newest == oldest_reg);
    assign out_free   = !ov_reg || !result_stall;
    assign ns_field   = {c2_reg, c1_reg[7:1]};
    assign nr_field   = {c4_reg, c3_reg[7:1]};
    assign slot_a     = next_slot(oldest_reg, eff_k);
    assign slot_b     = empty_reg ? '0 : nxt_newest;

    apci_win_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (SLW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        start_next     = start_reg;
        lenb_next      = lenb_reg;
        msize_next     = msize_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        c3_next        = c3_reg;
        c4_next        = c4_reg;
        ssize_next     = ssize_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        empty_next     = empty_reg;
        send_cnt_next  = send_cnt_reg;
        recv_cnt_next  = recv_cnt_reg;
        unconf_next    = unconf_reg;
        ack_flag_next  = ack_flag_reg;
        seq_next       = seq_reg;
        iframe_next    = iframe_reg;
        nval_next      = nval_reg;
        wrapped_next   = wrapped_reg;
        before_next    = before_reg;
        guard_next     = guard_reg;
        rs_status_next = rs_status_reg;
        rs_has_next    = rs_has_reg;
        rs_len_next    = rs_len_reg;
        rs_c1_next     = rs_c1_reg;
        rs_c2_next     = rs_c2_reg;
        rs_c3_next     = rs_c3_reg;
        rs_c4_next     = rs_c4_reg;
        rs_dlv_next    = rs_dlv_reg;
        two_next       = two_reg;
        ov_next        = ov_reg && result_stall;
        o_status_next  = o_status_reg;
        o_has_next     = o_has_reg;
        o_len_next     = o_len_reg;
        o_c1_next      = o_c1_reg;
        o_c2_next      = o_c2_reg;
        o_c3_next      = o_c3_reg;
        o_c4_next      = o_c4_reg;
        o_dlv_next     = o_dlv_reg;
        o_wrdy_next    = o_wrdy_reg;
        o_ack_next     = o_ack_reg;
        o_unc_next     = o_unc_reg;
        o_last_next    = o_last_reg;
        ring_we        = 1'b0;
        ring_waddr     = slot_b;
        ring_wdata     = send_cnt_reg + SW'(1);
        ring_re        = 1'b0;
        ring_raddr     = newest_reg;
        seq_ok         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next       = command;
                    start_next     = start_byte;
                    lenb_next      = length_byte;
                    msize_next     = msg_size;
                    c1_next        = ctl1;
                    c2_next        = ctl2;
                    c3_next        = ctl3;
                    c4_next        = ctl4;
                    ssize_next     = send_size;
                    rs_status_next = apci_win_pkg::ST_OK;
                    rs_has_next    = 1'b0;
                    rs_len_next    = '0;
                    rs_c1_next     = '0;
                    rs_c2_next     = '0;
                    rs_c3_next     = '0;
                    rs_c4_next     = '0;
                    rs_dlv_next    = 1'b0;
                    two_next       = 1'b0;
                    state_next     = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_EMIT1;
                if (cmd_reg == apci_win_pkg::CMD_SEND)
                begin
                    if (win_full)
                    begin
                        rs_status_next = apci_win_pkg::ST_WINDOW_FULL;
                    end
                    else
                    begin
                        ring_we       = 1'b1;
                        if (empty_reg)
                        begin
                            oldest_next = '0;
                        end
                        newest_next   = slot_b;
                        empty_next    = 1'b0;
                        rs_has_next   = 1'b1;
                        rs_len_next   = ssize_reg - 8'd2;
                        rs_c1_next    = {send_cnt_reg[6:0], 1'b0};
                        rs_c2_next    = send_cnt_reg[14:7];
                        rs_c3_next    = {recv_cnt_reg[6:0], 1'b0};
                        rs_c4_next    = recv_cnt_reg[14:7];
                        send_cnt_next = send_cnt_reg + SW'(1);
                        unconf_next   = '0;
                        ack_flag_next = 1'b0;
                    end
                end
                else if (msize_reg < 9'd3)
                begin
                    rs_status_next = apci_win_pkg::ST_TOO_SHORT;
                end
                else if (start_reg != apci_win_pkg::START_BYTE)
                begin
                    rs_status_next = apci_win_pkg::ST_BAD_START;
                end
                else if ({1'b0, lenb_reg} != msize_reg - 9'd2)
                begin
                    rs_status_next = apci_win_pkg::ST_BAD_LENGTH;
                end
                else if (!c1_reg[0] || c1_reg == apci_win_pkg::CTL_S_FRAME)
                begin
                    // i frame or s frame: both walk the ring with n(r)
                    if (!c1_reg[0] && msize_reg < 9'd7)
                    begin
                        rs_status_next = apci_win_pkg::ST_I_SHORT;
                    end
                    else if (!c1_reg[0] && ns_field != recv_cnt_reg)
                    begin
                        ack_flag_next  = 1'b1;
                        rs_status_next = apci_win_pkg::ST_NS_MISMATCH;
                    end
                    else
                    begin
                        if (!c1_reg[0])
                        begin
                            ack_flag_next = 1'b1;
                        end
                        iframe_next = !c1_reg[0];
                        seq_next    = nr_field;
                        if (empty_reg)
                        begin
                            if (nr_field == send_cnt_reg)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                rs_status_next = apci_win_pkg::ST_NR_RANGE;
                            end
                        end
                        else
                        begin
                            ring_re    = 1'b1;
                            ring_raddr = newest_reg;
                            state_next = S_RDN;
                        end
                    end
                end
                else if ((c1_reg & apci_win_pkg::MASK_TESTFR_ACT) ==
                         apci_win_pkg::MASK_TESTFR_ACT)
                begin
                    rs_has_next = 1'b1;
                    rs_len_next = apci_win_pkg::U_FRAME_LENGTH;
                    rs_c1_next  = apci_win_pkg::REPLY_TESTFR_CON;
                end
                else if ((c1_reg & apci_win_pkg::MASK_STARTDT) ==
                         apci_win_pkg::MASK_STARTDT)
                begin
                    rs_has_next = 1'b1;
                    rs_len_next = apci_win_pkg::U_FRAME_LENGTH;
                    rs_c1_next  = apci_win_pkg::REPLY_STARTDT_CON;
                end
                else if ((c1_reg & apci_win_pkg::MASK_STOPDT) ==
                         apci_win_pkg::MASK_STOPDT)
                begin
                    // own s frame first, then the confirmation
                    unconf_next   = '0;
                    ack_flag_next = 1'b0;
                    rs_has_next   = 1'b1;
                    rs_len_next   = apci_win_pkg::U_FRAME_LENGTH;
                    rs_c1_next    = apci_win_pkg::REPLY_S_FRAME;
                    rs_c3_next    = {recv_cnt_reg[6:0], 1'b0};
                    rs_c4_next    = recv_cnt_reg[14:7];
                    two_next      = 1'b1;
                end
                // testfr con and unknown control fields give a bare ok
            end

            S_RDN:
            begin
                nval_next  = ring_rdata;
                ring_re    = 1'b1;
                ring_raddr = oldest_reg;
                state_next = S_RDO;
            end

            S_RDO:
            begin
                // ring_rdata holds the oldest entry; the walk then reads the following entries
                if (ring_rdata <= nval_reg)
                begin
                    seq_ok       = (seq_reg >= ring_rdata) && (seq_reg <= nval_reg);
                    wrapped_next = 1'b0;
                end
                else
                begin
                    seq_ok       = (seq_reg >= ring_rdata) || (seq_reg <= nval_reg);
                    wrapped_next = 1'b1;
                end
                before_next = (ring_rdata == '0) ? apci_win_pkg::SEQ_MAX
                                                 : ring_rdata - SW'(1);
                if (before_next == seq_reg)
                begin
                    seq_ok = 1'b1;
                end
                guard_next = '0;
                if (seq_ok)
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    rs_status_next = apci_win_pkg::ST_NR_RANGE;
                    state_next     = S_EMIT1;
                end
            end

            S_LOOP:
            begin
                if (guard_reg == GUARD_END ||
                    (!wrapped_reg && seq_reg < ring_rdata) || seq_reg == before_reg)
                begin
                    state_next = S_ACK;
                end
                else if (ring_rdata == seq_reg)
                begin
                    if (oldest_reg == newest_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        oldest_next = slot_a;
                    end
                    state_next = S_ACK;
                end
                else
                begin
                    oldest_next = slot_a;
                    if (slot_a == nxt_newest)
                    begin
                        empty_next = 1'b1;
                        state_next = S_ACK;
                    end
                    else
                    begin
                        ring_re    = 1'b1;
                        ring_raddr = slot_a;
                        guard_next = guard_reg + GW'(1);
                    end
                end
            end

            S_ACK:
            begin
                if (iframe_reg)
                begin
                    recv_cnt_next = recv_cnt_reg + SW'(1);
                    if (unconf_reg < apci_win_pkg::SEQ_MAX)
                    begin
                        unconf_next = unconf_reg + SW'(1);
                    end
                    rs_dlv_next = 1'b1;
                end
                state_next = S_EMIT1;
            end

            S_EMIT1:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = rs_status_reg;
                    o_has_next    = rs_has_reg;
                    o_len_next    = rs_len_reg;
                    o_c1_next     = rs_c1_reg;
                    o_c2_next     = rs_c2_reg;
                    o_c3_next     = rs_c3_reg;
                    o_c4_next     = rs_c4_reg;
                    o_dlv_next    = rs_dlv_reg;
                    o_wrdy_next   = !win_full;
                    o_ack_next    = ack_flag_reg;
                    o_unc_next    = unconf_reg;
                    o_last_next   = !two_reg;
                    state_next    = two_reg ? S_EMIT2 : S_IDLE;
                end
            end

            S_EMIT2:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = apci_win_pkg::ST_OK;
                    o_has_next    = 1'b1;
                    o_len_next    = apci_win_pkg::U_FRAME_LENGTH;
                    o_c1_next     = apci_win_pkg::REPLY_STOPDT_CON;
                    o_c2_next     = '0;
                    o_c3_next     = '0;
                    o_c4_next     = '0;
                    o_dlv_next    = 1'b0;
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wsize_reg    <= apci_win_pkg::WINDOW_SIZE_RST;
            oldest_reg   <= '0;
            newest_reg   <= '0;
            empty_reg    <= 1'b1;
            send_cnt_reg <= '0;
            recv_cnt_reg <= '0;
            unconf_reg   <= '0;
            ack_flag_reg <= 1'b0;
            guard_reg    <= '0;
            two_reg      <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (window_size_we)
            begin
                wsize_reg <= window_size;
            end
            oldest_reg   <= oldest_next;
            newest_reg   <= newest_next;
            empty_reg    <= empty_next;
            send_cnt_reg <= send_cnt_next;
            recv_cnt_reg <= recv_cnt_next;
            unconf_reg   <= unconf_next;
            ack_flag_reg <= ack_flag_next;
            guard_reg    <= guard_next;
            two_reg      <= two_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        start_reg     <= start_next;
        lenb_reg      <= lenb_next;
        msize_reg     <= msize_next;
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        c3_reg        <= c3_next;
        c4_reg        <= c4_next;
        ssize_reg     <= ssize_next;
        seq_reg       <= seq_next;
        iframe_reg    <= iframe_next;
        nval_reg      <= nval_next;
        wrapped_reg   <= wrapped_next;
        before_reg    <= before_next;
        rs_status_reg <= rs_status_next;
        rs_has_reg    <= rs_has_next;
        rs_len_reg    <= rs_len_next;
        rs_c1_reg     <= rs_c1_next;
        rs_c2_reg     <= rs_c2_next;
        rs_c3_reg     <= rs_c3_next;
        rs_c4_reg     <= rs_c4_next;
        rs_dlv_reg    <= rs_dlv_next;
        o_status_reg  <= o_status_next;
        o_has_reg     <= o_has_next;
        o_len_reg     <= o_len_next;
        o_c1_reg      <= o_c1_next;
        o_c2_reg      <= o_c2_next;
        o_c3_reg      <= o_c3_next;
        o_c4_reg      <= o_c4_next;
        o_dlv_reg     <= o_dlv_next;
        o_wrdy_reg    <= o_wrdy_next;
        o_ack_reg     <= o_ack_next;
        o_unc_reg     <= o_unc_next;
        o_last_reg    <= o_last_next;
    end

    assign item_stall           = (state_reg != S_IDLE);
    assign result_valid         = ov_reg;
    assign status               = o_status_reg;
    assign has_frame            = o_has_reg;
    assign out_length           = o_len_reg;
    assign out_c1               = o_c1_reg;
    assign out_c2               = o_c2_reg;
    assign out_c3               = o_c3_reg;
    assign out_c4               = o_c4_reg;
    assign deliver_payload      = o_dlv_reg;
    assign window_ready         = o_wrdy_reg;
    assign ack_timer_running    = o_ack_reg;
    assign unconfirmed_received = o_unc_reg;
    assign last                 = o_last_reg;

    // only the stopdt reply pair has a non-final result, and it is an ok frame
    `ASSERT_IMPL(a_first_of_pair, result_valid && !last, has_frame && status == apci_win_pkg::ST_OK, "non-final result is not a frame")
    // delivered payload only for an ok i frame with nothing to send
    `ASSERT_IMPL(a_deliver_ok, result_valid && deliver_payload, !has_frame && status == apci_win_pkg::ST_OK, "payload delivered on bad result")
    // a refused send leaves the window full
    `ASSERT_IMPL(a_full_refuse, result_valid && status == apci_win_pkg::ST_WINDOW_FULL, !window_ready && !has_frame, "window full result with room")
    // a loaded result waits while stalled
    `ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid, "stalled result dropped")

endmodule

/* hdl/apci_win_ring.sv */
// ring of pending acknowledgement numbers: one write port, one registered read port
// depends on apci_win_pkg
`timescale 1ns / 1ps

module apci_win_ring #(
    parameter int DEPTH = apci_win_pkg::WINDOW_DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [apci_win_pkg::SEQ_W-1:0] wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [apci_win_pkg::SEQ_W-1:0] rdata
);

    logic [apci_win_pkg::SEQ_W-1:0] mem [DEPTH];
    logic [apci_win_pkg::SEQ_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
